// ===== src/fp2un_pkg.sv =====
// ----------------------------------------------------------------------------
// fp2un_pkg: shared types and constants
// Float pixel to unorm conversion: lane side-band, control word, full scale.
// ----------------------------------------------------------------------------
package fp2un_pkg;

  localparam int DIV_STEPS = 26;              // quotient bits per divide
  localparam int LANE_LAT  = DIV_STEPS + 4;   // lane input to lane output regs
  localparam int NUM_LANES = 4;

  localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
  localparam logic [31:0] INF_BITS = 32'h7F80_0000;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;

  localparam logic [1:0] REG_DEPTH   = 2'd0;
  localparam logic [1:0] REG_PREMULT = 2'd1;
  localparam logic [1:0] REG_CHANS   = 2'd2;

  typedef enum logic [1:0] {
    K_ZERO = 2'd0,
    K_FULL = 2'd1,
    K_QNT  = 2'd2
  } kind_e;

  // value = mant * 2^(expo - 150) when kind is K_QNT
  typedef struct packed {
    kind_e              kind;
    logic               div;
    logic signed [9:0]  expo;
    logic [23:0]        mant;
  } side_t;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic [3:0] used;
  } ctl_t;

  function automatic logic [31:0] full_scale(logic [1:0] depth);
    logic [31:0] m;
    unique case (depth)
      DEPTH_8:  m = 32'h0000_00FF;
      DEPTH_16: m = 32'h0000_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== src/fp2un_div.sv =====
// ----------------------------------------------------------------------------
// fp2un_div: pipelined mantissa divider
// Restoring division, one quotient bit per stage, side-band carried along.
// ----------------------------------------------------------------------------
module fp2un_div (
  input  logic              clk_i,
  input  fp2un_pkg::side_t  side_i,
  input  logic [23:0]       mc_i,
  input  logic [23:0]       ma_i,
  output fp2un_pkg::side_t  side_o,
  output logic [25:0]       quot_o,
  output logic              sticky_o
);
  import fp2un_pkg::*;

  logic [24:0] r_q    [0:DIV_STEPS];
  logic [25:0] q_q    [0:DIV_STEPS];
  logic [23:0] ma_q   [0:DIV_STEPS];
  side_t       side_q [0:DIV_STEPS];

  logic [24:0] r_d [1:DIV_STEPS];
  logic [25:0] q_d [1:DIV_STEPS];

  always_comb begin
    for (int j = 1; j <= DIV_STEPS; j++) begin
      if (r_q[j-1] >= {1'b0, ma_q[j-1]}) begin
        r_d[j] = {r_q[j-1][23:0] - ma_q[j-1], 1'b0};
        q_d[j] = {q_q[j-1][24:0], 1'b1};
      end else begin
        r_d[j] = {r_q[j-1][23:0], 1'b0};
        q_d[j] = {q_q[j-1][24:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q[0]    <= {1'b0, mc_i};
    q_q[0]    <= '0;
    ma_q[0]   <= ma_i;
    side_q[0] <= side_i;
    for (int j = 1; j <= DIV_STEPS; j++) begin
      r_q[j]    <= r_d[j];
      q_q[j]    <= q_d[j];
      ma_q[j]   <= ma_q[j-1];
      side_q[j] <= side_q[j-1];
    end
  end

  assign side_o   = side_q[DIV_STEPS];
  assign quot_o   = q_q[DIV_STEPS];
  assign sticky_o = |r_q[DIV_STEPS];

endmodule

// ===== src/fp2un_lane.sv =====
// ----------------------------------------------------------------------------
// fp2un_lane: one channel lane
// Classify, optional divide by alpha with round to nearest even, quantize.
// ----------------------------------------------------------------------------
module fp2un_lane (
  input  logic        clk_i,
  input  logic [1:0]  depth_i,
  input  logic        div_en_i,
  input  logic [31:0] c_i,
  input  logic [31:0] a_i,
  output logic [31:0] val_o
);
  import fp2un_pkg::*;

  logic [7:0]  ec, ea;
  logic [22:0] fc;
  logic        c_nan, c_inf;
  side_t       side_in;

  assign ec    = c_i[30:23];
  assign fc    = c_i[22:0];
  assign ea    = a_i[30:23];
  assign c_nan = (ec == 8'hFF) && (fc != '0);
  assign c_inf = (ec == 8'hFF) && (fc == '0);

  always_comb begin
    side_in.kind = K_ZERO;
    side_in.div  = 1'b0;
    side_in.expo = 10'sd1;
    side_in.mant = {1'b0, fc};
    if (!div_en_i) begin
      if (c_nan || c_i[31] || c_i == '0) begin
        side_in.kind = K_ZERO;
      end else if (c_i >= ONE_BITS) begin
        side_in.kind = K_FULL;
      end else begin
        side_in.kind = K_QNT;
        if (ec != '0) begin
          side_in.expo = $signed({2'b00, ec});
          side_in.mant = {1'b1, fc};
        end
      end
    end else begin
      // tiny quotients (from zero or subnormal colour) quantize to zero
      if (c_nan || ea == 8'hFF || c_i[31] || ec == '0) begin
        side_in.kind = K_ZERO;
      end else if (c_inf) begin
        side_in.kind = K_FULL;
      end else begin
        side_in.kind = K_QNT;
        side_in.div  = 1'b1;
        side_in.expo = $signed({2'b00, ec}) - $signed({2'b00, ea}) + 10'sd127;
      end
    end
  end

  side_t       dv_side;
  logic [25:0] dv_quot;
  logic        dv_sticky;

  fp2un_div u_div (
    .clk_i    (clk_i),
    .side_i   (side_in),
    .mc_i     ({1'b1, fc}),
    .ma_i     ({1'b1, a_i[22:0]}),
    .side_o   (dv_side),
    .quot_o   (dv_quot),
    .sticky_o (dv_sticky)
  );

  // round quotient to single
  side_t             rn_d, rn_q;
  logic [23:0]       rm;
  logic              rg, rs;
  logic [24:0]       rsum;
  logic signed [9:0] re;

  always_comb begin
    rn_d = dv_side;
    if (dv_quot[25]) begin
      rm = dv_quot[25:2];
      rg = dv_quot[1];
      rs = dv_quot[0] | dv_sticky;
      re = dv_side.expo;
    end else begin
      rm = dv_quot[24:1];
      rg = dv_quot[0];
      rs = dv_sticky;
      re = dv_side.expo - 10'sd1;
    end
    rsum = {1'b0, rm} + {24'd0, rg & (rs | rm[0])};
    if (rsum[24]) begin
      rsum = 25'h080_0000;
      re   = re + 10'sd1;
    end
    if (dv_side.div) begin
      rn_d.mant = rsum[23:0];
      rn_d.expo = re;
      rn_d.kind = (re >= 10'sd127) ? K_FULL : K_QNT;
    end
  end

  always_ff @(posedge clk_i) begin
    rn_q <= rn_d;
  end

  // multiply by full scale
  logic [31:0]        m_full;
  logic signed [10:0] k_full;
  logic [55:0]        prod_q;
  logic [5:0]         k_q;
  kind_e              kind_q;

  assign m_full = full_scale(depth_i);
  assign k_full = 11'sd150 - 11'(rn_q.expo);

  always_ff @(posedge clk_i) begin
    prod_q <= 56'(rn_q.mant) * 56'(m_full);
    k_q    <= k_full[5:0];
    if (rn_q.kind == K_QNT && k_full > 11'sd57) begin
      kind_q <= K_ZERO;
    end else begin
      kind_q <= rn_q.kind;
    end
  end

  // round half up and scale down
  logic [57:0] qsum;
  logic [57:0] qshift;

  assign qsum   = {2'b00, prod_q} + (58'd1 << (k_q - 6'd1));
  assign qshift = qsum >> k_q;

  always_ff @(posedge clk_i) begin
    unique case (kind_q)
      K_FULL:  val_o <= m_full;
      K_QNT:   val_o <= qshift[31:0];
      default: val_o <= '0;
    endcase
  end

endmodule

// ===== src/fp2un_merge.sv =====
// ----------------------------------------------------------------------------
// fp2un_merge: output stage
// Gathers lane results, blanks unused lanes, drives the result strobe.
// ----------------------------------------------------------------------------
module fp2un_merge (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fp2un_pkg::ctl_t   ctl_i,
  input  logic [31:0]       lane0_i,
  input  logic [31:0]       lane1_i,
  input  logic [31:0]       lane2_i,
  input  logic [31:0]       lane3_i,
  output logic              done_o,
  output logic              last_o,
  output logic [31:0]       chan0_o,
  output logic [31:0]       chan1_o,
  output logic [31:0]       chan2_o,
  output logic [31:0]       chan3_o
);
  import fp2un_pkg::*;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_o  <= ctl_i.last;
    chan0_o <= ctl_i.used[0] ? lane0_i : '0;
    chan1_o <= ctl_i.used[1] ? lane1_i : '0;
    chan2_o <= ctl_i.used[2] ? lane2_i : '0;
    chan3_o <= ctl_i.used[3] ? lane3_i : '0;
  end

endmodule

// ===== src/float_pixel_to_unorm_convert_top.sv =====
// ----------------------------------------------------------------------------
// float_pixel_to_unorm_convert_top: float pixel to unorm converter
// Four lanes turn IEEE single channels into 8/16/32-bit unorm values.
// ----------------------------------------------------------------------------
// Usage:
//   A pixel word is taken at each clock edge with start_i high; busy_o is
//   always low, so one pixel per clock is sustained.
//   The converted word shows on chan*_out_o / last_out_o for one cycle with
//   done_o high. The delay from the pixel being taken to its result is set
//   by the 26-stage pipelined divider in each colour lane (one quotient bit
//   per stage), plus round, multiply, shift and merge.
//   Results come out in order, one per accepted pixel.
//   Config (cfg_we_i, cfg_idx_i, cfg_data_i) is written with cfg_we_i high:
//   index 0 output depth, 1 premultiplied, 2 channels used. Write only when
//   the pipeline is empty.
//   Reset clears the pipeline valid bits and sets depth 8 bit, straight
//   alpha, four channels. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
module float_pixel_to_unorm_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [2:0]  cfg_data_i,
  input  logic [31:0] chan0_bits_i,
  input  logic [31:0] chan1_bits_i,
  input  logic [31:0] chan2_bits_i,
  input  logic [31:0] chan3_bits_i,
  input  logic        last_pixel_i,
  output logic        done_o,
  output logic [31:0] chan0_out_o,
  output logic [31:0] chan1_out_o,
  output logic [31:0] chan2_out_o,
  output logic [31:0] chan3_out_o,
  output logic        last_out_o
);
  import fp2un_pkg::*;

  logic [1:0] depth_q;
  logic       premult_q;
  logic [2:0] chans_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q   <= DEPTH_8;
      premult_q <= 1'b0;
      chans_q   <= 3'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DEPTH:   depth_q   <= cfg_data_i[1:0];
        REG_PREMULT: premult_q <= cfg_data_i[0];
        REG_CHANS:   chans_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // alpha normalize when premultiplied and alpha > 1.0 (NaN excluded)
  logic        div_en;
  logic [31:0] c3;
  assign div_en = premult_q && !chan3_bits_i[31] && chan3_bits_i > ONE_BITS &&
                  chan3_bits_i <= INF_BITS;
  assign c3     = div_en ? ONE_BITS : chan3_bits_i;

  ctl_t ctl_in;
  ctl_t ctl_q [0:LANE_LAT-1];

  always_comb begin
    ctl_in.valid = start_i;
    ctl_in.last  = last_pixel_i;
    for (int i = 0; i < NUM_LANES; i++) begin
      ctl_in.used[i] = premult_q || (chans_q > 3'(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0] <= ctl_in;
      for (int i = 1; i < LANE_LAT; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  logic [31:0] lane_val [0:NUM_LANES-1];

  fp2un_lane u_lane0 (
    .clk_i    (clk_i),
    .depth_i  (depth_q),
    .div_en_i (div_en),
    .c_i      (chan0_bits_i),
    .a_i      (chan3_bits_i),
    .val_o    (lane_val[0])
  );

  fp2un_lane u_lane1 (
    .clk_i    (clk_i),
    .depth_i  (depth_q),
    .div_en_i (div_en),
    .c_i      (chan1_bits_i),
    .a_i      (chan3_bits_i),
    .val_o    (lane_val[1])
  );

  fp2un_lane u_lane2 (
    .clk_i    (clk_i),
    .depth_i  (depth_q),
    .div_en_i (div_en),
    .c_i      (chan2_bits_i),
    .a_i      (chan3_bits_i),
    .val_o    (lane_val[2])
  );

  fp2un_lane u_lane3 (
    .clk_i    (clk_i),
    .depth_i  (depth_q),
    .div_en_i (1'b0),
    .c_i      (c3),
    .a_i      (chan3_bits_i),
    .val_o    (lane_val[3])
  );

  fp2un_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_q[LANE_LAT-1]),
    .lane0_i (lane_val[0]),
    .lane1_i (lane_val[1]),
    .lane2_i (lane_val[2]),
    .lane3_i (lane_val[3]),
    .done_o  (done_o),
    .last_o  (last_out_o),
    .chan0_o (chan0_out_o),
    .chan1_o (chan1_out_o),
    .chan2_o (chan2_out_o),
    .chan3_o (chan3_out_o)
  );

endmodule
